[hw/rtl/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// RGB median filter package
// Shared widths, register indexes, command codes and pixel types.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int PIX_W          = 8;
    localparam int RGB_W          = 3 * PIX_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_WIDTH_W    = 11;
    localparam int CFG_HEIGHT_W   = 13;
    localparam int CFG_RADIUS_W   = 2;
    localparam int ROW_W          = 12;
    localparam int HEIGHT_CAP     = 4096;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 2;
    localparam int OUT_FIFO_DEPTH = 8;

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;
    localparam logic [CFG_RADIUS_W-1:0] RST_WINDOW_RADIUS = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_WINDOW_RADIUS = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef logic [PIX_W-1:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

endpackage

[hw/rtl/rmf_pix_in_if.sv]
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying a command and one RGB pixel.
// ----------------------------------------------------------------------------
interface rmf_pix_in_if;
    import rmf_pkg::*;

    logic        valid;
    logic        ready;
    logic        cmd;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

[hw/rtl/rmf_pix_out_if.sv]
// ----------------------------------------------------------------------------
// Pixel output channel
// Valid/ready channel carrying one filtered RGB pixel and a frame end mark.
// ----------------------------------------------------------------------------
interface rmf_pix_out_if;
    import rmf_pkg::*;

    logic        valid;
    logic        ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic        frame_last;

    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

[hw/rtl/rmf_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rmf_cfg_if;
    import rmf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/rmf_median.sv]
// ----------------------------------------------------------------------------
// Window median, one color channel
// Two register stages: pairwise compare matrix, then ranks; the element whose
// rank is the middle one is selected.
// ----------------------------------------------------------------------------
module rmf_median #(
    parameter int  MAX_RADIUS = rmf_pkg::DEF_MAX_RADIUS,
    localparam int SIDE       = 2 * MAX_RADIUS + 1,
    localparam int N          = SIDE * SIDE,
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1)
) (
    input  logic                     i_clk,
    input  logic [RAD_W-1:0]         i_rad,
    input  logic [rmf_pkg::PIX_W-1:0] i_val [N],
    output logic [rmf_pkg::PIX_W-1:0] o_med
);
    import rmf_pkg::*;

    localparam int RANK_W = $clog2(N);

    logic [N-1:0]      act;
    logic [RANK_W-1:0] half;
    logic [N-1:0]      r_lt [N];
    t_chan             r_v3 [N];
    t_chan             r_v4 [N];
    logic [N-1:0]      r_act3;
    logic [N-1:0]      r_act4;
    logic [RANK_W-1:0] r_half3;
    logic [RANK_W-1:0] r_half4;
    logic [RANK_W-1:0] r_rank [N];

    // element k sits at row k/SIDE, column k%SIDE; only rows and columns 0..2r (the active (2r+1)^2 square) count
    for (genvar k = 0; k < N; k++) begin : g_act
        assign act[k] = ((RAD_W + 1)'(k / SIDE) <= {i_rad, 1'b0})
                     && ((RAD_W + 1)'(k % SIDE) <= {i_rad, 1'b0});
    end

    // middle index of a (2r+1)^2 window is 2r^2 + 2r
    assign half = RANK_W'(2 * int'(i_rad) * int'(i_rad) + 2 * int'(i_rad));

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                // ties break on position so every rank is taken exactly once
                r_lt[i][j] <= (i != j) && act[j]
                           && ((i_val[j] < i_val[i]) || ((i_val[j] == i_val[i]) && (j < i)));
            end
            r_v3[i] <= i_val[i];
        end
        r_act3  <= act;
        r_half3 <= half;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            r_rank[i] <= RANK_W'($countones(r_lt[i]));
            r_v4[i]   <= r_v3[i];
        end
        r_act4  <= r_act3;
        r_half4 <= r_half3;
    end

    always_comb begin
        o_med = '0;
        for (int i = 0; i < N; i++) begin
            if (r_act4[i] && (r_rank[i] == r_half4)) begin
                o_med = o_med | r_v4[i];
            end
        end
    end

endmodule

[hw/rtl/rgb_median_filter.sv]
// ----------------------------------------------------------------------------
// RGB median filter
// Streaming (2R+1)x(2R+1) per-channel median over raster-order RGB frames;
// border pixels pass through, flush transactions drain the tail of a frame.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | transaction when
//  i_pix    | in  | cmd, red_in, green_in, blue_in            | valid && ready
//  o_pix    | out | red_out, green_out, blue_out, frame_last  | valid && ready
//  i_cfg    | in  | index, data                               | valid && ready
//
//  One transaction per clock while ready is high. A result passes through the line
//  store read, the window shift, the two rank stages and the FIFO write before it leaves.
//  An 8-entry output FIFO holds results; i_pix.ready drops only when the FIFO plus
//  results in flight fill it. No clearing pass after reset; i_cfg is always ready.
//  Geometry is sampled at the first pixel of each frame.
// ----------------------------------------------------------------------------
module rgb_median_filter #(
    parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = rmf_pkg::DEF_MAX_RADIUS
) (
    input logic         i_clk,
    input logic         i_rst_n,
    rmf_pix_in_if.sink  i_pix,
    rmf_pix_out_if.source o_pix,
    rmf_cfg_if.sink     i_cfg
);
    import rmf_pkg::*;

    localparam int SIDE      = 2 * MAX_RADIUS + 1;
    localparam int N         = SIDE * SIDE;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FW_W      = $clog2(MAX_WIDTH + 1);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int LAG_MAX   = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
    localparam int LAG_W     = $clog2(LAG_MAX + 1);
    localparam int DLY_DEPTH = LAG_MAX + 1;
    localparam int DLY_AW    = $clog2(DLY_DEPTH);
    localparam int LINE_W    = 2 * MAX_RADIUS * RGB_W;
    localparam int FIFO_AW   = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W     = $clog2(OUT_FIFO_DEPTH + 1);

    typedef struct packed {
        logic             valid;
        logic             med;
        logic             last;
        logic [RAD_W-1:0] rad;
    } t_side;

    typedef struct packed {
        t_rgb pix;
        logic last;
    } t_out;

    // configuration
    logic [CFG_WIDTH_W-1:0]  r_cfg_w;
    logic [CFG_HEIGHT_W-1:0] r_cfg_h;
    logic [CFG_RADIUS_W-1:0] r_cfg_r;

    // frame geometry and position
    logic [FW_W-1:0]         r_fw, n_fw, sat_w, eff_fw;
    logic [CFG_HEIGHT_W-1:0] r_fh, n_fh, sat_h, eff_fh;
    logic [RAD_W-1:0]        r_fr, n_fr, sat_r, eff_fr;
    logic [LAG_W-1:0]        r_lag, n_lag, lag_cfg, eff_lag;
    logic [COL_W-1:0]        r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0]        r_in_row, n_in_row, r_out_row, n_out_row;
    logic                    r_frame_in, n_frame_in;
    logic [LAG_W-1:0]        r_pend, n_pend;
    logic [DLY_AW-1:0]       r_wptr, n_wptr, r_optr, n_optr;

    logic accept, first, is_pix, emit, interior, last;
    logic [FW_W-1:0]           in_col_inc, out_col_inc;
    logic [CFG_HEIGHT_W-1:0]   in_row_inc, out_row_inc;
    logic [CFG_HEIGHT_W+1:0]   oc_ext, or_ext, fr_ext;
    t_rgb                      in_pix;

    // memories
    t_rgb              mem_dly [DLY_DEPTH];
    logic [LINE_W-1:0] mem_line [MAX_WIDTH];
    t_rgb              r_dly_q;
    logic [LINE_W-1:0] r_line_q;

    // pipeline
    t_side             r_s1, r_s2, r_s3, r_s4;
    logic              r_s1_wr, r_s1_fwd;
    logic [COL_W-1:0]  r_s1_col;
    t_rgb              r_s1_pix, r_s2_pass, r_s3_pass, r_s4_pass;
    logic              r_fwd_v;
    logic [COL_W-1:0]  r_fwd_addr;
    logic [LINE_W-1:0] r_fwd_data;
    logic [LINE_W-1:0] line_old, line_wdata;
    t_rgb              col_vec [SIDE];
    t_rgb              r_win [SIDE][SIDE];
    t_chan             win_r [N];
    t_chan             win_g [N];
    t_chan             win_b [N];
    t_chan             med_r, med_g, med_b;

    // output queue
    t_out              r_fifo [OUT_FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt, r_credit;
    logic              take;
    t_out              s4_out;

    // ---------------- configuration port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_IMAGE_WIDTH;
            r_cfg_h <= RST_IMAGE_HEIGHT;
            r_cfg_r <= RST_WINDOW_RADIUS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_WIDTH:   r_cfg_w <= i_cfg.data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  r_cfg_h <= i_cfg.data[CFG_HEIGHT_W-1:0];
                CFG_WINDOW_RADIUS: r_cfg_r <= i_cfg.data[CFG_RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated geometry from the registers
    always_comb begin
        if (r_cfg_w == '0) begin
            sat_w = FW_W'(1);
        end else if (r_cfg_w > MAX_WIDTH) begin
            sat_w = FW_W'(MAX_WIDTH);
        end else begin
            sat_w = FW_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            sat_h = CFG_HEIGHT_W'(1);
        end else if (r_cfg_h > HEIGHT_CAP) begin
            sat_h = CFG_HEIGHT_W'(HEIGHT_CAP);
        end else begin
            sat_h = r_cfg_h;
        end
        if (r_cfg_r > MAX_RADIUS) begin
            sat_r = RAD_W'(MAX_RADIUS);
        end else begin
            sat_r = RAD_W'(r_cfg_r);
        end
        lag_cfg = LAG_W'(sat_r) * LAG_W'(sat_w) + LAG_W'(sat_r);
    end

    // ---------------- input side control ----------------
    assign take   = o_pix.valid && o_pix.ready;
    assign accept = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_credit < CNT_W'(OUT_FIFO_DEPTH));
    assign in_pix = '{red: i_pix.red_in, green: i_pix.green_in, blue: i_pix.blue_in};

    assign first  = (r_in_col == '0) && (r_in_row == '0);
    assign is_pix = accept && (i_pix.cmd == CMD_PIXEL) && !r_frame_in;

    assign eff_fw  = (is_pix && first) ? sat_w   : r_fw;
    assign eff_fh  = (is_pix && first) ? sat_h   : r_fh;
    assign eff_fr  = (is_pix && first) ? sat_r   : r_fr;
    assign eff_lag = (is_pix && first) ? lag_cfg : r_lag;

    assign emit = (is_pix && (r_pend >= eff_lag)) || (accept && r_frame_in);

    assign in_col_inc  = FW_W'(r_in_col) + FW_W'(1);
    assign out_col_inc = FW_W'(r_out_col) + FW_W'(1);
    assign in_row_inc  = CFG_HEIGHT_W'(r_in_row) + CFG_HEIGHT_W'(1);
    assign out_row_inc = CFG_HEIGHT_W'(r_out_row) + CFG_HEIGHT_W'(1);

    assign oc_ext = (CFG_HEIGHT_W + 2)'(r_out_col);
    assign or_ext = (CFG_HEIGHT_W + 2)'(r_out_row);
    assign fr_ext = (CFG_HEIGHT_W + 2)'(eff_fr);

    assign interior = (eff_fr != '0)
                   && (or_ext >= fr_ext) && (or_ext + fr_ext < (CFG_HEIGHT_W + 2)'(eff_fh))
                   && (oc_ext >= fr_ext) && (oc_ext + fr_ext < (CFG_HEIGHT_W + 2)'(eff_fw));
    assign last = (out_col_inc == eff_fw) && (out_row_inc == eff_fh);

    always_comb begin
        n_fw       = r_fw;
        n_fh       = r_fh;
        n_fr       = r_fr;
        n_lag      = r_lag;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_frame_in = r_frame_in;
        n_wptr     = r_wptr;
        n_optr     = r_optr;
        n_pend     = r_pend + LAG_W'(is_pix) - LAG_W'(emit);

        if (is_pix) begin
            n_fw  = eff_fw;
            n_fh  = eff_fh;
            n_fr  = eff_fr;
            n_lag = eff_lag;
            n_wptr = (r_wptr == DLY_AW'(DLY_DEPTH - 1)) ? '0 : r_wptr + DLY_AW'(1);
            if (in_col_inc == eff_fw) begin
                n_in_col = '0;
                if (in_row_inc == eff_fh) begin
                    n_in_row   = '0;
                    n_frame_in = 1'b1;
                end else begin
                    n_in_row = ROW_W'(in_row_inc);
                end
            end else begin
                n_in_col = COL_W'(in_col_inc);
            end
        end

        if (emit) begin
            n_optr = (r_optr == DLY_AW'(DLY_DEPTH - 1)) ? '0 : r_optr + DLY_AW'(1);
            if (out_col_inc == eff_fw) begin
                n_out_col = '0;
                n_out_row = ROW_W'(out_row_inc);
            end else begin
                n_out_col = COL_W'(out_col_inc);
            end
            // frame done: return to the start of a new frame
            if (last) begin
                n_in_col   = '0;
                n_in_row   = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_frame_in = 1'b0;
                n_pend     = '0;
                n_wptr     = '0;
                n_optr     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw       <= FW_W'(640);
            r_fh       <= CFG_HEIGHT_W'(480);
            r_fr       <= RAD_W'(1);
            r_lag      <= LAG_W'(641);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_frame_in <= 1'b0;
            r_pend     <= '0;
            r_wptr     <= '0;
            r_optr     <= '0;
        end else begin
            r_fw       <= n_fw;
            r_fh       <= n_fh;
            r_fr       <= n_fr;
            r_lag      <= n_lag;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_frame_in <= n_frame_in;
            r_pend     <= n_pend;
            r_wptr     <= n_wptr;
            r_optr     <= n_optr;
        end
    end

    // ---------------- memories ----------------
    // center delay line: pixel p is read back lag pixels after it was written
    always_ff @(posedge i_clk) begin
        if (is_pix) begin
            mem_dly[r_wptr] <= in_pix;
        end
        r_dly_q <= mem_dly[r_optr];
    end

    // line store: entry c holds the 2R rows above at column c, newest in the low slot
    always_ff @(posedge i_clk) begin
        if (r_s1_wr) begin
            mem_line[r_s1_col] <= line_wdata;
        end
        r_line_q <= mem_line[r_in_col];
    end

    // the previous pixel may have written the same column (one-pixel-wide frame)
    assign line_old   = (r_fwd_v && (r_fwd_addr == r_s1_col)) ? r_fwd_data : r_line_q;
    assign line_wdata = {line_old[LINE_W-RGB_W-1:0], r_s1_pix};

    always_comb begin
        col_vec[0] = r_s1_pix;
        for (int k = 1; k < SIDE; k++) begin
            col_vec[k] = line_old[(k - 1) * RGB_W +: RGB_W];
        end
    end

    // ---------------- pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_s2     <= '0;
            r_s3     <= '0;
            r_s4     <= '0;
            r_s1_wr  <= 1'b0;
            r_fwd_v  <= 1'b0;
        end else begin
            r_s1     <= '{valid: emit, med: interior, last: last, rad: eff_fr};
            r_s2     <= r_s1;
            r_s3     <= r_s2;
            r_s4     <= r_s3;
            r_s1_wr  <= is_pix;
            r_fwd_v  <= r_s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col   <= r_in_col;
        r_s1_pix   <= in_pix;
        r_s1_fwd   <= is_pix && (r_pend == '0);
        r_fwd_addr <= r_s1_col;
        r_fwd_data <= line_wdata;
        r_s2_pass  <= r_s1_fwd ? r_s1_pix : r_dly_q;
        r_s3_pass  <= r_s2_pass;
        r_s4_pass  <= r_s3_pass;
    end

    // window: shift in the new column on every pixel, column 0 newest
    always_ff @(posedge i_clk) begin
        if (r_s1_wr) begin
            for (int rr = 0; rr < SIDE; rr++) begin
                r_win[rr][0] <= col_vec[rr];
                for (int cc = 1; cc < SIDE; cc++) begin
                    r_win[rr][cc] <= r_win[rr][cc - 1];
                end
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_win
        assign win_r[k] = r_win[k / SIDE][k % SIDE].red;
        assign win_g[k] = r_win[k / SIDE][k % SIDE].green;
        assign win_b[k] = r_win[k / SIDE][k % SIDE].blue;
    end

    rmf_median #(.MAX_RADIUS(MAX_RADIUS)) u_med_r (
        .i_clk (i_clk), .i_rad (r_s2.rad), .i_val (win_r), .o_med (med_r)
    );
    rmf_median #(.MAX_RADIUS(MAX_RADIUS)) u_med_g (
        .i_clk (i_clk), .i_rad (r_s2.rad), .i_val (win_g), .o_med (med_g)
    );
    rmf_median #(.MAX_RADIUS(MAX_RADIUS)) u_med_b (
        .i_clk (i_clk), .i_rad (r_s2.rad), .i_val (win_b), .o_med (med_b)
    );

    assign s4_out.pix  = r_s4.med ? t_rgb'{red: med_r, green: med_g, blue: med_b}
                                  : r_s4_pass;
    assign s4_out.last = r_s4.last;

    // ---------------- output queue ----------------
    always_ff @(posedge i_clk) begin
        if (r_s4.valid) begin
            r_fifo[r_wp] <= s4_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            if (r_s4.valid) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (take) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            r_cnt    <= r_cnt + CNT_W'(r_s4.valid) - CNT_W'(take);
            // hold a slot for every result in flight
            r_credit <= r_credit + CNT_W'(emit) - CNT_W'(take);
        end
    end

    assign o_pix.valid      = (r_cnt != '0);
    assign o_pix.red_out    = r_fifo[r_rp].pix.red;
    assign o_pix.green_out  = r_fifo[r_rp].pix.green;
    assign o_pix.blue_out   = r_fifo[r_rp].pix.blue;
    assign o_pix.frame_last = r_fifo[r_rp].last;

endmodule
